// ===== hdl/ralu_pkg.sv =====
// ----------------------------------------------------------------------------
// ralu_pkg
// shared types and codes of the eight-bit register alu
// ----------------------------------------------------------------------------
package ralu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CmdW  = 5;
  localparam int unsigned FlagW = 5;

  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagV = 3;
  localparam int unsigned FlagN = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADC  = 5'd0,
    CMD_SBC  = 5'd1,
    CMD_INCM = 5'd2,
    CMD_DECM = 5'd3,
    CMD_INX  = 5'd4,
    CMD_INY  = 5'd5,
    CMD_DEX  = 5'd6,
    CMD_DEY  = 5'd7,
    CMD_LDA  = 5'd8,
    CMD_LDX  = 5'd9,
    CMD_LDY  = 5'd10,
    CMD_STA  = 5'd11,
    CMD_STX  = 5'd12,
    CMD_STY  = 5'd13,
    CMD_TAX  = 5'd14,
    CMD_TXA  = 5'd15,
    CMD_TAY  = 5'd16,
    CMD_TYA  = 5'd17,
    CMD_CLC  = 5'd18,
    CMD_SEC  = 5'd19,
    CMD_CLI  = 5'd20,
    CMD_SEI  = 5'd21,
    CMD_CLV  = 5'd22
  } cmd_e;

  typedef struct packed {
    logic [DataW-1:0] acc;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [FlagW-1:0] flags;
  } arch_state_t;

endpackage

// ===== hdl/ralu_if.sv =====
// ----------------------------------------------------------------------------
// ralu_cmd_if / ralu_res_if
// valid/ready channels for instruction words and result words
// ----------------------------------------------------------------------------
interface ralu_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [ralu_pkg::CmdW-1:0]     command;
  logic [ralu_pkg::DataW-1:0]    operand;

  modport source (output valid, output command, output operand, input ready);
  modport sink   (input valid, input command, input operand, output ready);
endinterface

interface ralu_res_if;
  logic                          valid;
  logic                          ready;
  logic [ralu_pkg::DataW-1:0]    acc_out;
  logic [ralu_pkg::DataW-1:0]    x_out;
  logic [ralu_pkg::DataW-1:0]    y_out;
  logic [ralu_pkg::FlagW-1:0]    flags_out;
  logic                          write_valid;
  logic [ralu_pkg::DataW-1:0]    write_data;

  modport source (output valid, output acc_out, output x_out, output y_out,
                  output flags_out, output write_valid, output write_data,
                  input ready);
  modport sink   (input valid, input acc_out, input x_out, input y_out,
                  input flags_out, input write_valid, input write_data,
                  output ready);
endinterface

// ===== hdl/ralu_alu.sv =====
// ----------------------------------------------------------------------------
// ralu_alu
// execute logic: next register and flag state plus memory write word
// ----------------------------------------------------------------------------
module ralu_alu (
  input  ralu_pkg::arch_state_t        state_i,
  input  logic [ralu_pkg::CmdW-1:0]    command_i,
  input  logic [ralu_pkg::DataW-1:0]   operand_i,
  output ralu_pkg::arch_state_t        state_o,
  output logic                         write_valid_o,
  output logic [ralu_pkg::DataW-1:0]   write_data_o
);
  import ralu_pkg::*;

  logic [DataW-1:0] add_m;
  logic [DataW:0]   sum;
  logic [DataW-1:0] add_r;
  logic             add_v;
  logic [DataW-1:0] nz_val;
  logic             nz_en;

  assign add_m = (cmd_e'(command_i) == CMD_SBC) ? ~operand_i : operand_i;
  assign sum   = {1'b0, state_i.acc} + {1'b0, add_m} + (DataW+1)'(state_i.flags[FlagC]);
  assign add_r = sum[DataW-1:0];
  assign add_v = (~(state_i.acc[DataW-1] ^ add_m[DataW-1])) &
                 (state_i.acc[DataW-1] ^ add_r[DataW-1]);

  always_comb begin
    state_o       = state_i;
    write_valid_o = 1'b0;
    write_data_o  = '0;
    nz_val        = '0;
    nz_en         = 1'b0;
    unique case (cmd_e'(command_i))
      CMD_ADC, CMD_SBC: begin
        state_o.acc          = add_r;
        state_o.flags[FlagC] = sum[DataW];
        state_o.flags[FlagV] = add_v;
        nz_val = add_r;
        nz_en  = 1'b1;
      end
      CMD_INCM: begin
        write_data_o  = operand_i + DataW'(1);
        write_valid_o = 1'b1;
        nz_val = operand_i + DataW'(1);
        nz_en  = 1'b1;
      end
      CMD_DECM: begin
        write_data_o  = operand_i - DataW'(1);
        write_valid_o = 1'b1;
        nz_val = operand_i - DataW'(1);
        nz_en  = 1'b1;
      end
      CMD_INX: begin
        state_o.x = state_i.x + DataW'(1);
        nz_val = state_o.x;
        nz_en  = 1'b1;
      end
      CMD_INY: begin
        state_o.y = state_i.y + DataW'(1);
        nz_val = state_o.y;
        nz_en  = 1'b1;
      end
      CMD_DEX: begin
        state_o.x = state_i.x - DataW'(1);
        nz_val = state_o.x;
        nz_en  = 1'b1;
      end
      CMD_DEY: begin
        state_o.y = state_i.y - DataW'(1);
        nz_val = state_o.y;
        nz_en  = 1'b1;
      end
      CMD_LDA: begin
        state_o.acc = operand_i;
        nz_val = operand_i;
        nz_en  = 1'b1;
      end
      CMD_LDX: begin
        state_o.x = operand_i;
        nz_val = operand_i;
        nz_en  = 1'b1;
      end
      CMD_LDY: begin
        state_o.y = operand_i;
        nz_val = operand_i;
        nz_en  = 1'b1;
      end
      CMD_STA: begin
        write_data_o  = state_i.acc;
        write_valid_o = 1'b1;
      end
      CMD_STX: begin
        write_data_o  = state_i.x;
        write_valid_o = 1'b1;
      end
      CMD_STY: begin
        write_data_o  = state_i.y;
        write_valid_o = 1'b1;
      end
      CMD_TAX: begin
        state_o.x = state_i.acc;
        nz_val = state_i.acc;
        nz_en  = 1'b1;
      end
      CMD_TXA: begin
        state_o.acc = state_i.x;
        nz_val = state_i.x;
        nz_en  = 1'b1;
      end
      CMD_TAY: begin
        state_o.y = state_i.acc;
        nz_val = state_i.acc;
        nz_en  = 1'b1;
      end
      CMD_TYA: begin
        state_o.acc = state_i.y;
        nz_val = state_i.y;
        nz_en  = 1'b1;
      end
      CMD_CLC: state_o.flags[FlagC] = 1'b0;
      CMD_SEC: state_o.flags[FlagC] = 1'b1;
      CMD_CLI: state_o.flags[FlagI] = 1'b0;
      CMD_SEI: state_o.flags[FlagI] = 1'b1;
      CMD_CLV: state_o.flags[FlagV] = 1'b0;
      default: ;
    endcase
    if (nz_en) begin
      state_o.flags[FlagZ] = (nz_val == '0);
      state_o.flags[FlagN] = nz_val[DataW-1];
    end
  end

endmodule

// ===== hdl/eight_bit_register_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// eight_bit_register_alu_with_flags
// accumulator machine executing one register or alu instruction per word
// ----------------------------------------------------------------------------
// result path: command captured in the input register, then executed into the result register
// throughput: one instruction per cycle while results are taken, set by the single execute stage
// the result register holds a word while stalled and the input stage still fills
// reset: a, x, y and all flags cleared, both stages empty
module eight_bit_register_alu_with_flags (
  input  logic              clk_i,
  input  logic              rst_ni,
  ralu_cmd_if.sink          cmd_i,
  ralu_res_if.source        res_o
);
  import ralu_pkg::*;

  logic              in_valid_q;
  logic [CmdW-1:0]   command_q;
  logic [DataW-1:0]  operand_q;
  logic              out_valid_q;
  logic              write_valid_q;
  logic [DataW-1:0]  write_data_q;
  logic              write_valid_d;
  logic [DataW-1:0]  write_data_d;
  arch_state_t       state_q;
  arch_state_t       state_d;
  logic              exec;

  assign exec        = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || exec;

  ralu_alu u_alu (
    .state_i       (state_q),
    .command_i     (command_q),
    .operand_i     (operand_q),
    .state_o       (state_d),
    .write_valid_o (write_valid_d),
    .write_data_o  (write_data_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (cmd_i.ready) begin
        in_valid_q <= cmd_i.valid;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      command_q <= cmd_i.command;
      operand_q <= cmd_i.operand;
    end
    if (exec) begin
      write_valid_q <= write_valid_d;
      write_data_q  <= write_data_d;
    end
  end

  // architectural registers only move on execute, so they double as result
  assign res_o.valid       = out_valid_q;
  assign res_o.acc_out     = state_q.acc;
  assign res_o.x_out       = state_q.x;
  assign res_o.y_out       = state_q.y;
  assign res_o.flags_out   = state_q.flags;
  assign res_o.write_valid = write_valid_q;
  assign res_o.write_data  = write_data_q;

endmodule

// ===== hdl/ralu_chk.sv =====
// ----------------------------------------------------------------------------
// ralu_chk
// port level checks of the register alu, bound to the top level
// ----------------------------------------------------------------------------
module ralu_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [ralu_pkg::DataW-1:0]    acc_i,
  input logic [ralu_pkg::FlagW-1:0]    flags_i,
  input logic                          write_valid_i,
  input logic [ralu_pkg::DataW-1:0]    write_data_i
);
  import ralu_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(acc_i) && $stable(flags_i)
      && $stable(write_valid_i) && $stable(write_data_i))
    else $error("result word changed while stalled");

  a_no_stray_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !write_valid_i |-> write_data_i == '0)
    else $error("write data without write");

  a_nz_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(flags_i[FlagZ] && flags_i[FlagN]))
    else $error("zero and negative flags both set");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !res_valid_i)
    else $error("result valid right after reset");

endmodule

bind eight_bit_register_alu_with_flags ralu_chk u_ralu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .acc_i         (res_o.acc_out),
  .flags_i       (res_o.flags_out),
  .write_valid_i (res_o.write_valid),
  .write_data_i  (res_o.write_data)
);
